>>> sv/jise_pkg.sv
// jise_pkg: constants, opcodes and status codes of the jvm integer subset executor
// no dependencies
`timescale 1ns / 1ps
package jise_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int LOCAL_SLOTS = 256;
    localparam int CONST_SLOTS = 256;
    localparam int PC_BITS     = 16;
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int LOC_W = $clog2(LOCAL_SLOTS);
    localparam int CON_W = $clog2(CONST_SLOTS);

    localparam logic [1:0] FUNC_EXEC   = 2'd0;
    localparam logic [1:0] FUNC_CWR    = 2'd1;
    localparam logic [1:0] FUNC_RST    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [3:0] ST_OK = 4'd0, ST_HALT = 4'd1, ST_PCOUT = 4'd2, ST_UNK = 4'd3,
        ST_TRUNC = 4'd4, ST_UNDER = 4'd5, ST_LRANGE = 4'd6, ST_LUNINIT = 4'd7,
        ST_CRANGE = 4'd8, ST_DIVZ = 4'd9, ST_OVER = 4'd10;

    localparam logic [7:0] OP_ICONST0 = 8'h03, OP_ICONST5 = 8'h08, OP_BIPUSH = 8'h10,
        OP_LDC = 8'h12, OP_ILOAD = 8'h15, OP_ILOAD0 = 8'h1a, OP_ILOAD3 = 8'h1d,
        OP_ISTORE = 8'h36, OP_ISTORE0 = 8'h3b, OP_ISTORE3 = 8'h3e, OP_IADD = 8'h60,
        OP_ISUB = 8'h64, OP_IMUL = 8'h68, OP_IDIV = 8'h6c, OP_IFEQ = 8'h9f,
        OP_IFGT = 8'ha3, OP_GOTO = 8'ha7, OP_IRET = 8'hac, OP_RET = 8'hb1;

    localparam logic [0:0] CFG_LOCALS = 1'b0;
    localparam logic [0:0] CFG_CONSTS = 1'b1;
endpackage

>>> sv/jvm_int_subset_executor_top.sv
// jvm_int_subset_executor_top: executes one bytecode instruction per input transaction
// depends on jise_pkg
//
// slave stream carries one item per transaction: func in tuser, bytes and constant in tdata.
// master stream returns one status item per accepted item.
// config channel writes locals_in_use (index 0) and constants_in_use (index 1).
// stack, locals and constant pool sit in synchronous ram with registered read ports.
// each item runs through read, second read for two-operand instructions, execute with
// write-back, divide for idiv, and output states; constant writes, restart and the
// unused func go from the read state straight to output. idiv runs the bit-serial
// divider in the divide state.
// a new item is taken only in the idle state, once the last one has left the output
// state; a receiver that is not ready while a result is pending holds the item there.
// restart clears the 256 local valid flags at once; nothing else is swept.
// a result waits in the output register until taken; the next item may be taken and
// executed meanwhile, its result then waits in the output state. reset empties the
// stack, pc 0, flags clear, registers back to 16 and 0.
`timescale 1ns / 1ps
module jvm_int_subset_executor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[7:0] operand_hi[15:8] operand_lo[23:16] bytes_left[25:24]
    // const_index[33:26] const_value[65:34] zero pad [71:66]
    input  logic [71:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[3:0] exec_pc[19:4] next_pc[35:20] stack_depth[42:36] top_value[74:43]
    // run_stopped[75] return_present[76] return_word[108:77] zero pad [111:109]
    output logic [111:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import jise_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_RD1 = 3'd1, S_RD2 = 3'd2, S_EXE = 3'd3,
        S_DIV = 3'd4, S_OUT = 3'd5;

    logic [2:0] r_state;
    logic [31:0] r_stk [STACK_DEPTH];
    logic [31:0] r_loc [LOCAL_SLOTS];
    logic [31:0] r_con [CONST_SLOTS];
    logic [LOCAL_SLOTS-1:0] r_lvalid;
    logic [CNT_W-1:0] r_cnt;
    logic [PC_BITS-1:0] r_pc;
    logic r_halt, r_ret;
    logic [31:0] r_retv;
    logic [8:0] r_nloc, r_ncon;
    logic [71:0] r_d;
    logic [1:0] r_f;
    logic [31:0] r_b, r_a, r_top;
    logic [31:0] r_stk_q, r_loc_q, r_con_q;
    logic [3:0] r_st;
    logic [PC_BITS-1:0] r_epc;
    logic r_ov;
    logic [111:0] r_out;
    // divider
    logic [31:0] r_dq, r_dr, r_dd;
    logic [5:0] r_dn;
    logic r_dneg;

    logic [7:0] op, hi, lo;
    logic [1:0] left;
    assign op = r_d[7:0];
    assign hi = r_d[15:8];
    assign lo = r_d[23:16];
    assign left = r_d[25:24];

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;

    logic is_push_c, is_load, is_store, is_alu, is_cmp;
    assign is_push_c = (op >= OP_ICONST0 && op <= OP_ICONST5) || op == OP_BIPUSH || op == OP_LDC;
    assign is_load = op == OP_ILOAD || (op >= OP_ILOAD0 && op <= OP_ILOAD3);
    assign is_store = op == OP_ISTORE || (op >= OP_ISTORE0 && op <= OP_ISTORE3);
    assign is_alu = op == OP_IADD || op == OP_ISUB || op == OP_IMUL || op == OP_IDIV;
    assign is_cmp = op == OP_IFEQ || op == OP_IFGT;
    logic two_op;
    assign two_op = is_alu || is_cmp;

    logic [LOC_W-1:0] slot;
    always_comb begin
        if (op == OP_ILOAD || op == OP_ISTORE) slot = LOC_W'(hi);
        else if (is_load) slot = LOC_W'(op - OP_ILOAD0);
        else slot = LOC_W'(op - OP_ISTORE0);
    end
    logic [8:0] nloc, ncon;
    assign nloc = (r_nloc < 9'(LOCAL_SLOTS)) ? r_nloc : 9'(LOCAL_SLOTS);
    assign ncon = (r_ncon < 9'(CONST_SLOTS)) ? r_ncon : 9'(CONST_SLOTS);
    logic [8:0] slot9;
    assign slot9 = (op == OP_ILOAD || op == OP_ISTORE) ? {1'b0, hi} : 9'(slot);

    logic [PC_BITS-1:0] br_t;
    assign br_t = r_pc + PC_BITS'({{16{hi[7]}}, hi, lo});

    // execute decision
    logic [3:0] x_st;
    logic x_push, x_pop1, x_pop2, x_lwr, x_div, x_halt, x_ret;
    logic [31:0] x_v;
    logic [PC_BITS-1:0] x_pc;
    logic [31:0] mul_r;
    assign mul_r = r_a * r_b;
    always_comb begin
        x_st = ST_OK; x_push = 1'b0; x_pop1 = 1'b0; x_pop2 = 1'b0; x_lwr = 1'b0;
        x_div = 1'b0; x_halt = 1'b0; x_ret = 1'b0; x_v = '0; x_pc = r_pc;
        if (r_halt) x_st = ST_HALT;
        else if (left == 2'd0) x_st = ST_PCOUT;
        else if (is_push_c) begin
            if (op <= OP_ICONST5) x_v = 32'(op - OP_ICONST0);
            else if (op == OP_BIPUSH) x_v = {{24{hi[7]}}, hi};
            else x_v = r_con_q;
            if (op > OP_ICONST5 && left < 2'd2) x_st = ST_TRUNC;
            else if (op == OP_LDC && {1'b0, hi} >= ncon) x_st = ST_CRANGE;
            else if (r_cnt >= CNT_W'(STACK_DEPTH)) x_st = ST_OVER;
            else begin
                x_push = 1'b1;
                x_pc = r_pc + ((op > OP_ICONST5) ? PC_BITS'(2) : PC_BITS'(1));
            end
        end else if (is_load || is_store) begin
            x_v = r_loc_q;
            if (left < ((op == OP_ILOAD || op == OP_ISTORE) ? 2'd2 : 2'd1)) x_st = ST_TRUNC;
            else if (slot9 >= nloc) x_st = ST_LRANGE;
            else if (is_load && !r_lvalid[slot]) x_st = ST_LUNINIT;
            else if (is_load && r_cnt >= CNT_W'(STACK_DEPTH)) x_st = ST_OVER;
            else if (is_store && r_cnt == '0) x_st = ST_UNDER;
            else begin
                x_push = is_load; x_pop1 = is_store; x_lwr = is_store;
                x_pc = r_pc + ((op == OP_ILOAD || op == OP_ISTORE) ? PC_BITS'(2) : PC_BITS'(1));
            end
        end else if (is_alu) begin
            if (r_cnt < CNT_W'(2)) x_st = ST_UNDER;
            else if (op == OP_IDIV && r_b == '0) x_st = ST_DIVZ;
            else begin
                x_pop2 = 1'b1; x_push = 1'b1; x_pc = r_pc + PC_BITS'(1);
                x_div = op == OP_IDIV;
                unique case (op)
                    OP_IADD: x_v = r_a + r_b;
                    OP_ISUB: x_v = r_a - r_b;
                    OP_IMUL: x_v = mul_r;
                    default: x_v = '0;
                endcase
            end
        end else if (op == OP_GOTO) begin
            if (left < 2'd3) x_st = ST_TRUNC;
            else x_pc = br_t;
        end else if (is_cmp) begin
            if (left < 2'd3) x_st = ST_TRUNC;
            else if (r_cnt < CNT_W'(2)) x_st = ST_UNDER;
            else begin
                x_pop2 = 1'b1;
                if ((op == OP_IFEQ) ? (r_a == r_b) : ($signed(r_a) > $signed(r_b))) x_pc = br_t;
                else x_pc = r_pc + PC_BITS'(3);
            end
        end else if (op == OP_IRET) begin
            if (r_cnt == '0) x_st = ST_UNDER;
            else begin
                x_pop1 = 1'b1; x_ret = 1'b1; x_halt = 1'b1; x_pc = r_pc + PC_BITS'(1);
            end
        end else if (op == OP_RET) begin
            x_halt = 1'b1; x_pc = r_pc + PC_BITS'(1);
        end else x_st = ST_UNK;
    end

    // stack read address: entry below top in the first read, the one below that in the second
    logic [SP_W-1:0] rd_addr;
    logic [CNT_W-1:0] cm1, cm2, cm3;
    assign cm1 = r_cnt - CNT_W'(1);
    assign cm2 = r_cnt - CNT_W'(2);
    assign cm3 = r_cnt - CNT_W'(3);
    always_comb begin
        if (r_state == S_RD1) rd_addr = cm2[SP_W-1:0];
        else if (r_state == S_RD2) rd_addr = cm3[SP_W-1:0];
        else rd_addr = cm1[SP_W-1:0];
    end

    // divider step
    logic [32:0] d_trial;
    logic [31:0] d_rem;
    assign d_rem = {r_dr[30:0], r_dq[31]};
    assign d_trial = {1'b0, d_rem} - {1'b0, r_dd};

    logic [CNT_W-1:0] new_cnt;
    assign new_cnt = r_cnt - (x_pop2 ? CNT_W'(2) : (x_pop1 ? CNT_W'(1) : '0))
        + (x_push ? CNT_W'(1) : '0);
    logic [31:0] div_q;
    assign div_q = r_dneg ? (32'd0 - r_dq) : r_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_pc <= '0; r_halt <= 1'b0; r_ret <= 1'b0;
            r_retv <= '0; r_lvalid <= '0; r_nloc <= 9'd16; r_ncon <= 9'd0; r_ov <= 1'b0;
            r_top <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_LOCALS) r_nloc <= i_cfg_data;
                else r_ncon <= i_cfg_data;
            end
            if (r_state == S_OUT && (!r_ov || m_axis_tready)) r_ov <= 1'b1;
            else if (r_ov && m_axis_tready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_d <= s_axis_tdata; r_f <= s_axis_tuser; r_epc <= r_pc;
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    if (r_f == FUNC_CWR) begin
                        r_con[CON_W'(r_d[33:26])] <= r_d[65:34];
                        r_st <= ST_OK; r_state <= S_OUT;
                    end else if (r_f == FUNC_RST) begin
                        r_lvalid <= '0; r_cnt <= '0; r_pc <= '0; r_halt <= 1'b0;
                        r_ret <= 1'b0; r_retv <= '0; r_top <= '0;
                        r_st <= ST_OK; r_state <= S_OUT;
                    end else if (r_f == FUNC_EXEC) begin
                        r_b <= r_top;
                        r_state <= two_op ? S_RD2 : S_EXE;
                    end else begin
                        r_st <= ST_OK; r_state <= S_OUT;
                    end
                end
                S_RD2: begin
                    r_a <= r_stk_q; r_state <= S_EXE;
                end
                S_EXE: begin
                    r_st <= x_st;
                    if (x_st == ST_OK) begin
                        r_pc <= x_pc;
                        if (x_halt) r_halt <= 1'b1;
                        if (x_ret) begin r_ret <= 1'b1; r_retv <= r_top; end
                        if (x_lwr) begin r_loc[slot] <= r_top; r_lvalid[slot] <= 1'b1; end
                        if (x_div) begin
                            r_dq <= r_a[31] ? (32'd0 - r_a) : r_a;
                            r_dd <= r_b[31] ? (32'd0 - r_b) : r_b;
                            r_dr <= '0; r_dn <= 6'd0; r_dneg <= r_a[31] ^ r_b[31];
                            r_state <= S_DIV;
                        end else begin
                            r_cnt <= new_cnt;
                            if (x_push) begin
                                r_stk[(x_pop2 ? cm2[SP_W-1:0] : r_cnt[SP_W-1:0])] <= x_v;
                                r_top <= x_v;
                            end else if (x_pop2) r_top <= (r_cnt > CNT_W'(2)) ? r_stk_q : '0;
                            else if (x_pop1) r_top <= (r_cnt > CNT_W'(1)) ? r_stk_q : '0;
                            r_state <= S_OUT;
                        end
                    end else r_state <= S_OUT;
                end
                S_DIV: begin
                    if (r_dn == 6'd32) begin
                        r_stk[cm2[SP_W-1:0]] <= div_q; r_top <= div_q; r_cnt <= cm1;
                        r_state <= S_OUT;
                    end else begin
                        r_dn <= r_dn + 6'd1;
                        if (!d_trial[32]) begin
                            r_dr <= d_trial[31:0]; r_dq <= {r_dq[30:0], 1'b1};
                        end else begin
                            r_dr <= d_rem; r_dq <= {r_dq[30:0], 1'b0};
                        end
                    end
                end
                S_OUT: if (!r_ov || m_axis_tready) begin
                    r_out <= {3'b0, r_retv, r_ret, r_halt, r_top, 7'(r_cnt), 16'(r_pc),
                              16'(r_epc), r_st};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ram read ports: stack below top, local slot, constant entry
    always_ff @(posedge i_clk) begin
        r_stk_q <= r_stk[rd_addr];
        r_loc_q <= r_loc[slot];
        r_con_q <= r_con[CON_W'(hi)];
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> m_axis_tvalid) else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pending result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXE && r_halt) |=> $stable(r_cnt)) else $error("halted changed stack");
endmodule
